// ===== hdl/compacting_array_store_macros.svh =====
// Assertion macros for the compacting array store RTL.
`ifndef COMPACTING_ARRAY_STORE_MACROS_SVH
`define COMPACTING_ARRAY_STORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CAS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cas_pkg.sv =====
// Shared types and codes for the compacting array store.
`default_nettype none

package cas_pkg;

	// Command codes carried on the request tuser.
	localparam logic [2:0] CMD_APPEND    = 3'd0;
	localparam logic [2:0] CMD_DEL_INDEX = 3'd1;
	localparam logic [2:0] CMD_DEL_MATCH = 3'd2;
	localparam logic [2:0] CMD_READ      = 3'd3;
	localparam logic [2:0] CMD_FIND      = 3'd4;

	// Status codes carried on the response tuser.
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ_WAIT,
		S_SCAN,
		S_SHIFT,
		S_REPLY
	} cas_state_t;

	// Control strobes from the sequencer to the datapath.
	typedef struct packed {
		logic       idle;
		logic       wr_en;
		logic       wr_shift;
		logic       inc;
		logic       dec;
		logic       load_fval;
		logic       clr_fval;
		logic       load_out;
		logic [1:0] status;
	} cas_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cas_ctrl.sv =====
// Command sequencer: decodes a request, walks the store for scans and shifts.
`default_nettype none

module cas_ctrl #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        cmd,
	input  logic [7:0]        pos,
	input  logic [CW-1:0]     count,
	input  logic              match,
	input  logic              out_busy,
	output cas_pkg::cas_ctl_t ctl,
	output logic [AW-1:0]     rd_addr,
	output logic [AW-1:0]     wr_addr,
	output logic [AW-1:0]     hit_idx
);
	import cas_pkg::*;

	localparam int PW = (CW > 8) ? CW : 8;

	cas_state_t    state_q, state_d;
	logic [CW-1:0] ptr_q;
	logic          pend_q;
	logic [AW-1:0] pend_idx_q;
	logic [AW-1:0] hit_q;
	logic [1:0]    status_q;

	logic pos_in;
	logic full;
	logic more;
	logic hit;
	logic walk_end;

	// Conditions shared by next-state, output and register logic.
	assign pos_in   = PW'(pos) < PW'(count);
	assign full     = count == CW'(DEPTH);
	assign more     = ptr_q < count;
	assign hit      = pend_q && match;
	assign walk_end = !more && !pend_q;
	assign hit_idx  = hit_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (cmd)
					CMD_APPEND:    state_d = S_REPLY;
					CMD_DEL_INDEX: state_d = pos_in ? S_READ_WAIT : S_REPLY;
					CMD_READ:      state_d = pos_in ? S_READ_WAIT : S_REPLY;
					CMD_DEL_MATCH: state_d = S_SCAN;
					CMD_FIND:      state_d = S_SCAN;
					default:       state_d = S_REPLY;
				endcase
			end
			S_READ_WAIT: begin
				state_d = (cmd == CMD_DEL_INDEX) ? S_SHIFT : S_REPLY;
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (cmd == CMD_DEL_MATCH) ? S_SHIFT : S_REPLY;
				end else if (walk_end) begin
					state_d = S_REPLY;
				end
			end
			S_SHIFT: begin
				if (walk_end) state_d = S_REPLY;
			end
			S_REPLY: begin
				if (!out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control strobes and memory addresses.
	always_comb begin
		ctl        = '0;
		ctl.idle   = state_q == S_IDLE;
		ctl.status = status_q;
		rd_addr    = ptr_q[AW-1:0];
		wr_addr    = (state_q == S_SHIFT) ? pend_idx_q : count[AW-1:0];
		case (state_q)
			S_DECODE: begin
				ctl.clr_fval = 1'b1;
				rd_addr      = AW'(pos);
				if (cmd == CMD_APPEND && !full) begin
					ctl.wr_en = 1'b1;
					ctl.inc   = 1'b1;
				end
			end
			S_READ_WAIT: ctl.load_fval = 1'b1;
			S_SCAN:      ctl.load_fval = hit;
			S_SHIFT: begin
				ctl.wr_en    = pend_q;
				ctl.wr_shift = 1'b1;
				ctl.dec      = walk_end;
			end
			S_REPLY: ctl.load_out = !out_busy;
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk pointer, pending compare or write, hit index and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			hit_q      <= '0;
			status_q   <= STAT_DONE;
		end else begin
			case (state_q)
				S_DECODE: begin
					ptr_q  <= '0;
					pend_q <= 1'b0;
					hit_q  <= '0;
					if (cmd == CMD_APPEND) begin
						status_q <= full ? STAT_FULL : STAT_DONE;
					end else begin
						status_q <= STAT_MISS;
					end
				end
				S_READ_WAIT: begin
					hit_q    <= AW'(pos);
					status_q <= STAT_DONE;
					ptr_q    <= CW'(pos) + CW'(1);
					pend_q   <= 1'b0;
				end
				S_SCAN: begin
					if (hit) begin
						hit_q    <= pend_idx_q;
						status_q <= STAT_DONE;
						ptr_q    <= CW'(pend_idx_q) + CW'(1);
						pend_q   <= 1'b0;
					end else begin
						pend_q <= more;
						if (more) begin
							pend_idx_q <= ptr_q[AW-1:0];
							ptr_q      <= ptr_q + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					pend_q <= more;
					if (more) begin
						pend_idx_q <= ptr_q[AW-1:0] - AW'(1);
						ptr_q      <= ptr_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/compacting_array_store.sv =====
// Compacting array store: a packed array of signed words served by a command sequencer.
//
// Requests enter on the s_ group: tuser carries the command, tdata the
// position and the operand value. Each request gives exactly one response
// on the m_ group: tuser carries the status, tdata the element read or
// matched, its index and the fill count after the command.
// One request is worked on at a time; s_tready is high only while the
// sequencer is idle, and the next request can be taken in the cycle after the
// response register is loaded. Append, unused codes and any miss on an index
// go from decode straight to the reply step; a read or a delete at an index in
// range first reads that entry. Find and delete by match walk the store from
// index 0 until a hit or the fill count; a delete then moves every later
// entry down one place. The single read port of the store is walked one entry
// per cycle.
// The response register lets the next request be taken while a response
// waits; a stalled receiver holds the sequencer only at its reply step.
// Reset clears the fill count and the control state; the store contents are
// not cleared, since only entries below the count are ever used.
`default_nettype none
`include "compacting_array_store_macros.svh"

module compacting_array_store #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position [7:0], operand_value [39:8]
	input  logic [2:0]  s_tuser,   // command [2:0]
	// Response channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // found_value [31:0], found_index [39:32],
	                               // fill_count [48:40], zeros [55:49]
	output logic [1:0]  m_tuser    // status [1:0]
);
	import cas_pkg::*;

	cas_ctl_t      ctl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] hit_idx;

	logic [31:0]   store_q [DEPTH];
	logic [31:0]   rdata_q;
	logic [2:0]    cmd_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [CW-1:0] count_q;
	logic [31:0]   fval_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [31:0]   out_value_q;
	logic [7:0]    out_index_q;
	logic [8:0]    out_count_q;

	logic accept;
	logic match;
	logic out_busy;

	assign accept   = s_tvalid && s_tready;
	assign match    = rdata_q == val_q;
	assign out_busy = out_valid_q && !m_tready;
	assign s_tready = ctl.idle;

	// Sequencer.
	cas_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.cmd     (cmd_q),
		.pos     (pos_q),
		.count   (count_q),
		.match   (match),
		.out_busy(out_busy),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.hit_idx (hit_idx)
	);

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			pos_q <= s_tdata[7:0];
			val_q <= s_tdata[39:8];
		end
	end

	// Element store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			store_q[wr_addr] <= ctl.wr_shift ? rdata_q : val_q;
		end
		rdata_q <= store_q[rd_addr];
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.inc) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Value found by a read or a match, zero otherwise.
	always_ff @(posedge clk) begin
		if (ctl.clr_fval) begin
			fval_q <= '0;
		end else if (ctl.load_fval) begin
			fval_q <= rdata_q;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q <= ctl.status;
			out_value_q  <= fval_q;
			out_index_q  <= 8'(hit_idx);
			out_count_q  <= 9'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_count_q, out_index_q, out_value_q};

	// Checks on the sequencer and the fill count.
	`CAS_ASSERT_NEXT(a_busy_after_request, accept, !s_tready, "request taken while busy")
	`CAS_ASSERT_NOW(a_full_status, ctl.load_out && ctl.status == STAT_FULL, count_q == CW'(DEPTH), "full reported below depth")
	`CAS_ASSERT_NOW(a_dec_nonempty, ctl.dec, count_q != '0, "delete from empty store")
	`CAS_ASSERT_NOW(a_write_in_range, ctl.wr_en, CW'(wr_addr) <= count_q && count_q != CW'(DEPTH) || ctl.wr_shift, "append write out of range")
	`CAS_ASSERT_NOW(a_reply_free, ctl.load_out, !out_busy, "response overwritten while held")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the compacting array store: directed table, then randomised phases.
module tb_top;
	import cas_pkg::*;

	// Command codes the block leaves unused; each must be answered as a miss.
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	localparam int STORE_DEPTH = 256;
	localparam int DRAIN_CYCLES = STORE_DEPTH + 40;

	// One response as the block reports it.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_value;
		logic [7:0]  found_index;
		logic [8:0]  fill_count;
	} reply_t;

	// One request of the directed table; typed rows carry their own answer.
	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  pos;
		logic [31:0] operand;
		logic        typed;
		reply_t      reply;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// Every command but append against an empty store, unused codes included.
		'{CMD_READ,      8'd0,   32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		'{CMD_FIND,      8'd0,   32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		'{CMD_DEL_INDEX, 8'd0,   32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		'{CMD_DEL_MATCH, 8'd0,   32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		'{CMD_SPARE_LO,  8'd0,   32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		'{CMD_SPARE_MID, 8'hff,  32'hffff_ffff,  1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		'{CMD_SPARE_HI,  8'h80,  32'h8000_0000,  1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd0}},
		// Appends of the value extremes, starting from empty, with one duplicate.
		'{CMD_APPEND,    8'd0,   32'h8000_0000,  1'b1, '{STAT_DONE, 32'd0, 8'd0, 9'd1}},
		'{CMD_APPEND,    8'hff,  32'h7fff_ffff,  1'b1, '{STAT_DONE, 32'd0, 8'd0, 9'd2}},
		'{CMD_APPEND,    8'd0,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 8'd0, 9'd3}},
		'{CMD_APPEND,    8'd0,   32'hffff_ffff,  1'b1, '{STAT_DONE, 32'd0, 8'd0, 9'd4}},
		'{CMD_APPEND,    8'd0,   32'h7fff_ffff,  1'b1, '{STAT_DONE, 32'd0, 8'd0, 9'd5}},
		// Reads in range, far out of range and exactly at the count.
		'{CMD_READ,      8'd0,   32'd0,          1'b0, '0},
		'{CMD_READ,      8'hff,  32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd5}},
		'{CMD_READ,      8'd5,   32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd5}},
		// Searches must return the first of two equal entries.
		'{CMD_FIND,      8'd0,   32'h7fff_ffff,  1'b0, '0},
		'{CMD_FIND,      8'd0,   32'd12345,      1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd5}},
		'{CMD_DEL_MATCH, 8'd0,   32'h7fff_ffff,  1'b0, '0},
		// Deletes at the head and at the tail, then misses.
		'{CMD_DEL_INDEX, 8'd0,   32'd0,          1'b0, '0},
		'{CMD_DEL_INDEX, 8'd2,   32'd0,          1'b0, '0},
		'{CMD_DEL_MATCH, 8'd0,   32'h5555_5555,  1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd2}},
		'{CMD_DEL_INDEX, 8'hff,  32'd0,          1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd2}},
		'{CMD_FIND,      8'd0,   32'h8000_0000,  1'b1, '{STAT_MISS, 32'd0, 8'd0, 9'd2}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // position [7:0], operand_value [39:8]
	logic [2:0]  s_tuser = '0;   // command [2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // found_value [31:0], found_index [39:32],
	                             // fill_count [48:40], zeros [55:49]
	logic [1:0]  m_tuser;        // status [1:0]

	// Mirror of the store contents and the fill count.
	logic [31:0] mirror_store [STORE_DEPTH];
	int          mirror_count = 0;

	reply_t      awaited_replies [$];
	int          mismatch_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	compacting_array_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one command to the mirror and returns the reply it must produce.
	function automatic reply_t apply_command(input logic [2:0] cmd, input logic [7:0] pos,
			input logic [31:0] operand);
		reply_t r;
		int     hit;
		int     i;
		r = '{status: STAT_MISS, found_value: '0, found_index: '0, fill_count: '0};
		hit = -1;
		case (cmd)
			CMD_APPEND: begin
				if (mirror_count >= STORE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					mirror_store[mirror_count] = operand;
					mirror_count++;
					r.status = STAT_DONE;
				end
			end
			CMD_DEL_INDEX, CMD_READ: begin
				if (int'(pos) < mirror_count)
					hit = int'(pos);
			end
			CMD_DEL_MATCH, CMD_FIND: begin
				for (i = 0; i < mirror_count && hit < 0; i++)
					if (mirror_store[i] == operand)
						hit = i;
			end
			default: ;
		endcase
		if (hit >= 0) begin
			r.status = STAT_DONE;
			r.found_value = mirror_store[hit];
			r.found_index = 8'(hit);
			// Deletes close the gap by moving every later entry down one place.
			if (cmd == CMD_DEL_INDEX || cmd == CMD_DEL_MATCH) begin
				for (i = hit; i + 1 < mirror_count; i++)
					mirror_store[i] = mirror_store[i + 1];
				mirror_count--;
			end
		end
		r.fill_count = 9'(mirror_count);
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Presents one request after an optional gap and records its expected reply.
	task automatic send_request(input logic [2:0] cmd, input logic [7:0] pos,
			input logic [31:0] operand, input logic typed, input reply_t typed_reply);
		reply_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {operand, pos};
		do @(posedge clk); while (!s_tready);
		predicted = apply_command(cmd, pos, operand);
		awaited_replies.push_back(typed ? typed_reply : predicted);
	endtask

	// Draws an operand: mostly stored values and small ones, so that searches hit
	// and duplicates build up, with extremes and full-range values mixed in.
	function automatic logic [31:0] pick_operand();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45 && mirror_count > 0)
			return mirror_store[$urandom_range(mirror_count - 1)];
		if (roll < 65)
			return 32'($urandom_range(15)) - 32'd8;
		if (roll < 72) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	// One random request; append_pct steers the store towards full or empty.
	task automatic random_request(input int append_pct);
		logic [2:0]  cmd;
		logic [7:0]  pos;
		int          roll;
		roll = $urandom_range(99);
		if (roll < append_pct) begin
			cmd = CMD_APPEND;
		end else if (roll >= 98) begin
			case ($urandom_range(2))
				0: cmd = CMD_SPARE_LO;
				1: cmd = CMD_SPARE_MID;
				default: cmd = CMD_SPARE_HI;
			endcase
		end else begin
			case ($urandom_range(3))
				0: cmd = CMD_DEL_INDEX;
				1: cmd = CMD_DEL_MATCH;
				2: cmd = CMD_READ;
				default: cmd = CMD_FIND;
			endcase
		end
		if (mirror_count > 0 && $urandom_range(99) < 80)
			pos = 8'($urandom_range(mirror_count - 1));
		else
			pos = 8'($urandom_range(255));
		send_request(cmd, pos, pick_operand(), 1'b0, '0);
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Response checker: every reply is compared with the oldest expectation.
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: m_tuser, found_value: m_tdata[31:0],
				found_index: m_tdata[39:32], fill_count: m_tdata[48:40]};
			if (awaited_replies.size() == 0) begin
				flag_mismatch($sformatf("response with none expected: %p", got));
			end else begin
				want = awaited_replies.pop_front();
				if (got.status != want.status)
					flag_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.found_value != want.found_value)
					flag_mismatch($sformatf("found_value %h, expected %h",
						got.found_value, want.found_value));
				if (got.found_index != want.found_index)
					flag_mismatch($sformatf("found_index %0d, expected %0d",
						got.found_index, want.found_index));
				if (got.fill_count != want.fill_count)
					flag_mismatch($sformatf("fill_count %0d, expected %0d",
						got.fill_count, want.fill_count));
			end
		end
	end

	// Stimulus: directed table, then four randomised phases with different idling.
	initial begin
		int phase;
		int append_pct;
		int requests;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DIRECTED_ROWS; row++)
			send_request(DIRECTED[row].cmd, DIRECTED[row].pos, DIRECTED[row].operand,
				DIRECTED[row].typed, DIRECTED[row].reply);

		// Mixed traffic, a fill to full and beyond, churn near full, then a drain.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  append_pct = 55;
					requests = 230; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  append_pct = 93;
					requests = 320; end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; append_pct = 50;
					requests = 200; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; append_pct = 15;
					requests = 250; end
			endcase
			repeat (requests) random_request(append_pct);
		end
		s_tvalid <= 1'b0;

		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_replies.size() != 0 || mismatch_count != 0) begin
			if (awaited_replies.size() != 0)
				flag_mismatch($sformatf("%0d responses never arrived",
					awaited_replies.size()));
			$display("compacting_array_store regression: fail");
		end else begin
			$display("compacting_array_store regression: pass");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#8_000_000;
		$display("compacting_array_store regression: fail");
		$finish;
	end

endmodule
